[rtl/swhsd_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the single-wire humidity sensor decoder
// no dependencies

package swhsd_pkg;

   localparam int LEAD_EDGES_DEF = 4;
   localparam int FRAME_BITS     = 40;
   localparam int EDGE_CNT_W     = 7;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_ADDR_W     = 4;

   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_EDGE  = 2'd1,
      CMD_CHECK = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_GOOD    = 2'd0,
      ST_BAD_SUM = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   localparam logic [1:0] REG_SENSOR_KIND = 2'd0;
   localparam logic [1:0] REG_TIMEOUT     = 2'd1;
   localparam logic [1:0] REG_TEMP_OFF    = 2'd2;
   localparam logic [1:0] REG_HUM_OFF     = 2'd3;

   typedef struct packed {
      logic        sensor_kind;
      logic [15:0] timeout_us;
      logic [10:0] temp_off;
      logic [10:0] hum_off;
   } cfg_type;

   // work handed from front to back
   typedef struct packed {
      logic                  timeout;
      logic [FRAME_BITS-1:0] frame;
   } job_type;

endpackage

[rtl/swhsd_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and response transactions
// no dependencies

interface swhsd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] time_us;

   modport source (output valid, output cmd, output time_us, input ready);
   modport sink   (input valid, input cmd, input time_us, output ready);
endinterface

interface swhsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [17:0] humidity_tenths;
   logic signed [16:0] temperature_tenths;
   logic [39:0]        raw_frame;

   modport source (output valid, output status, output humidity_tenths,
                   output temperature_tenths, output raw_frame, input ready);
   modport sink   (input valid, input status, input humidity_tenths,
                   input temperature_tenths, input raw_frame, output ready);
endinterface

[rtl/single_wire_humidity_sensor_decoder_core.sv]
`timescale 1ns / 1ps
// result path: a result transaction reaches rsp_if after the edge or time check that
// ends the reading is accepted, by way of the job queue write, then the back response register
// throughput: one request transaction per cycle; ready drops only when the two-entry
// job queue is full while the response side stalls
// reset: synchronous, active high; clears edge state, queue and registers to defaults
// depends on swhsd_pkg, swhsd_if, swhsd_front, swhsd_queue, swhsd_back

module single_wire_humidity_sensor_decoder_core #(
   parameter int LEAD_EDGES = swhsd_pkg::LEAD_EDGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   swhsd_req_if.sink                        req_if,
   swhsd_rsp_if.source                      rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [swhsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   swhsd_pkg::cfg_type cfg_ff, cfg_in;
   swhsd_pkg::job_type push_job, head;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   logic               push, pop, full, not_empty;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            swhsd_pkg::REG_SENSOR_KIND: cfg_in.sensor_kind = csr_pwdata[0];
            swhsd_pkg::REG_TIMEOUT:     cfg_in.timeout_us  = csr_pwdata[15:0];
            swhsd_pkg::REG_TEMP_OFF:    cfg_in.temp_off    = csr_pwdata[10:0];
            swhsd_pkg::REG_HUM_OFF:     cfg_in.hum_off     = csr_pwdata[10:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         swhsd_pkg::REG_SENSOR_KIND: csr_prdata = {31'd0, cfg_ff.sensor_kind};
         swhsd_pkg::REG_TIMEOUT:     csr_prdata = {16'd0, cfg_ff.timeout_us};
         swhsd_pkg::REG_TEMP_OFF:    csr_prdata = {21'd0, cfg_ff.temp_off};
         swhsd_pkg::REG_HUM_OFF:     csr_prdata = {21'd0, cfg_ff.hum_off};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_kind <= 1'b0;
         cfg_ff.timeout_us  <= swhsd_pkg::TIMEOUT_RESET;
         cfg_ff.temp_off    <= '0;
         cfg_ff.hum_off     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swhsd_front #(
      .LEAD_EDGES (LEAD_EDGES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .timeout_us (cfg_ff.timeout_us),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   swhsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   swhsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (not_empty),
      .job       (head),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

[rtl/swhsd_front.sv]
`timescale 1ns / 1ps
// front end: accepts request transactions, times edges, assembles the frame
// depends on swhsd_pkg, swhsd_if

module swhsd_front #(
   parameter int LEAD_EDGES = swhsd_pkg::LEAD_EDGES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   swhsd_req_if.sink            req_if,
   input  logic [15:0]          timeout_us,
   input  logic                 queue_full,
   output logic                 push,
   output swhsd_pkg::job_type   push_job
);

   localparam int TOTAL_EDGES = LEAD_EDGES + 2 * swhsd_pkg::FRAME_BITS;
   localparam int CW          = swhsd_pkg::EDGE_CNT_W;
   localparam int FB          = swhsd_pkg::FRAME_BITS;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   last_ff, last_in;
   logic [31:0]   low_ff, low_in;
   logic [FB-1:0] frame_ff, frame_in;

   logic          accept;
   logic [31:0]   gap;
   logic [CW-1:0] cnt_inc;
   logic [CW-1:0] k;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign gap          = req_if.time_us - last_ff;
   assign cnt_inc      = cnt_ff + CW'(1);
   assign k            = cnt_ff - CW'(LEAD_EDGES);

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      low_in   = low_ff;
      frame_in = frame_ff;
      push     = 1'b0;
      push_job = '0;
      if (accept) begin
         case (swhsd_pkg::cmd_type'(req_if.cmd))
            swhsd_pkg::CMD_START: begin
               busy_in  = 1'b1;
               cnt_in   = '0;
               last_in  = req_if.time_us;
               low_in   = '0;
               frame_in = '0;
            end
            swhsd_pkg::CMD_EDGE: begin
               if (busy_ff) begin
                  last_in = req_if.time_us;
                  if (cnt_ff >= CW'(LEAD_EDGES)) begin
                     if (!k[0]) begin
                        low_in = gap;
                     end else begin
                        frame_in = {frame_ff[FB-2:0], gap > low_ff};
                     end
                  end
                  cnt_in = cnt_inc;
                  if (cnt_inc >= CW'(TOTAL_EDGES)) begin
                     busy_in        = 1'b0;
                     push           = 1'b1;
                     push_job.frame = frame_in;
                  end
               end
            end
            swhsd_pkg::CMD_CHECK: begin
               if (busy_ff && (gap > {16'd0, timeout_us})) begin
                  busy_in          = 1'b0;
                  push             = 1'b1;
                  push_job.timeout = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         last_ff  <= '0;
         low_ff   <= '0;
         frame_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         low_ff   <= low_in;
         frame_ff <= frame_in;
      end
   end

endmodule

[rtl/swhsd_queue.sv]
`timescale 1ns / 1ps
// short job queue between front and back end
// depends on swhsd_pkg

module swhsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  swhsd_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output swhsd_pkg::job_type head
);

   localparam int D  = swhsd_pkg::QUEUE_DEPTH;
   localparam int PW = (D > 1) ? $clog2(D) : 1;
   localparam int CW = $clog2(D + 1);

   swhsd_pkg::job_type q_ff [D];
   logic [PW-1:0]      wr_ff, wr_in;
   logic [PW-1:0]      rd_ff, rd_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(D));
   assign not_empty = (cnt_ff != '0);
   assign head      = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(D - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(D - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/swhsd_back.sv]
`timescale 1ns / 1ps
// back end: checksum, format decode, calibration and response register
// depends on swhsd_pkg, swhsd_if

module swhsd_back (
   input  logic               clock,
   input  logic               reset,
   input  swhsd_pkg::cfg_type cfg,
   input  logic               job_valid,
   input  swhsd_pkg::job_type job,
   output logic               pop,
   swhsd_rsp_if.source        rsp_if
);

   logic [7:0]         b0, b1, b2, b3, b4;
   logic [7:0]         sum8;
   logic [11:0]        b0x10, b2x10;
   logic signed [17:0] hum_base, hum_off;
   logic signed [16:0] tmp_base, tmp_off;
   logic signed [16:0] mag;

   logic               valid_ff, valid_in;
   logic [1:0]         status_ff, status_in;
   logic signed [17:0] hum_ff, hum_in;
   logic signed [16:0] tmp_ff, tmp_in;
   logic [39:0]        raw_ff, raw_in;

   assign pop = job_valid && (!valid_ff || rsp_if.ready);

   assign b0 = job.frame[39:32];
   assign b1 = job.frame[31:24];
   assign b2 = job.frame[23:16];
   assign b3 = job.frame[15:8];
   assign b4 = job.frame[7:0];

   assign sum8    = b0 + b1 + b2 + b3;
   assign b0x10   = {1'b0, b0, 3'b000} + {3'b000, b0, 1'b0};
   assign b2x10   = {1'b0, b2, 3'b000} + {3'b000, b2, 1'b0};
   assign mag     = {2'b00, b2[6:0], b3};
   assign hum_off = {{7{cfg.hum_off[10]}}, cfg.hum_off};
   assign tmp_off = {{6{cfg.temp_off[10]}}, cfg.temp_off};

   always_comb begin
      if (cfg.sensor_kind) begin
         hum_base = {2'b00, b0, b1};
         tmp_base = b2[7] ? -mag : mag;
      end else begin
         hum_base = 18'(b0x10) + 18'(b1);
         if (b3[7]) begin
            tmp_base = -(17'sd10 + 17'(b2x10)) + 17'(b3[3:0]);
         end else begin
            tmp_base = 17'(b2x10) + 17'(b3[3:0]);
         end
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      hum_in    = hum_ff;
      tmp_in    = tmp_ff;
      raw_in    = raw_ff;
      if (pop) begin
         valid_in = 1'b1;
         if (job.timeout) begin
            status_in = swhsd_pkg::ST_TIMEOUT;
            hum_in    = '0;
            tmp_in    = '0;
            raw_in    = '0;
         end else if (b4 != sum8) begin
            status_in = swhsd_pkg::ST_BAD_SUM;
            hum_in    = '0;
            tmp_in    = '0;
            raw_in    = job.frame;
         end else begin
            status_in = swhsd_pkg::ST_GOOD;
            hum_in    = hum_base + hum_off;
            tmp_in    = tmp_base + tmp_off;
            raw_in    = job.frame;
         end
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      status_ff <= status_in;
      hum_ff    <= hum_in;
      tmp_ff    <= tmp_in;
      raw_ff    <= raw_in;
   end

   assign rsp_if.valid              = valid_ff;
   assign rsp_if.status             = status_ff;
   assign rsp_if.humidity_tenths    = hum_ff;
   assign rsp_if.temperature_tenths = tmp_ff;
   assign rsp_if.raw_frame          = raw_ff;

endmodule

[rtl/swhsd_checker.sv]
`timescale 1ns / 1ps
// port-level checks on the decoder core, attached by bind
// depends on swhsd_pkg, single_wire_humidity_sensor_decoder_core

module swhsd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic signed [17:0] rsp_humidity_tenths,
   input logic signed [16:0] rsp_temperature_tenths,
   input logic [39:0]       rsp_raw_frame,
   input logic              csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_raw_frame))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == swhsd_pkg::ST_GOOD ||
      rsp_status == swhsd_pkg::ST_BAD_SUM || rsp_status == swhsd_pkg::ST_TIMEOUT)
      else $error("unknown status code");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == swhsd_pkg::ST_TIMEOUT |->
      rsp_humidity_tenths == '0 && rsp_temperature_tenths == '0 && rsp_raw_frame == '0)
      else $error("timeout response carries data");

   a_bad_sum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == swhsd_pkg::ST_BAD_SUM |->
      rsp_humidity_tenths == '0 && rsp_temperature_tenths == '0)
      else $error("checksum failure carries readings");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr port not ready");

endmodule

bind single_wire_humidity_sensor_decoder_core swhsd_checker u_swhsd_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_if.valid),
   .rsp_ready              (rsp_if.ready),
   .rsp_status             (rsp_if.status),
   .rsp_humidity_tenths    (rsp_if.humidity_tenths),
   .rsp_temperature_tenths (rsp_if.temperature_tenths),
   .rsp_raw_frame          (rsp_if.raw_frame),
   .csr_pready             (csr_pready)
);

[tb/sv/tb_single_wire_humidity_sensor_decoder_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for single_wire_humidity_sensor_decoder_core
// replays edge-timed sensor readings and checks every response against a built-in decoder
// depends on swhsd_pkg, swhsd_if and the core rtl

module tb_single_wire_humidity_sensor_decoder_core;

   localparam int LEAD_COUNT     = swhsd_pkg::LEAD_EDGES_DEF;
   localparam int READING_EDGES  = LEAD_COUNT + 2 * swhsd_pkg::FRAME_BITS;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 1750;
   localparam int READING_TARGET = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      swhsd_pkg::status_type status;
      logic [17:0]           hum;
      logic [16:0]           temp;
      logic [39:0]           raw;
   } reading_type;

   localparam reading_type NO_READING = '0;

   typedef enum logic [1:0] {
      SEQ_STRAY,
      SEQ_FRAME,
      SEQ_TIMEOUT,
      SEQ_RESTART
   } seq_kind_type;

   typedef struct {
      seq_kind_type kind;
      logic [31:0]  base;
      logic [39:0]  frame;
      int           edges;
      logic [31:0]  gap;
      bit           typed;
      reading_type  want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [swhsd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                      csr_pwdata;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;

   swhsd_req_if req_bus ();
   swhsd_rsp_if rsp_bus ();

   // decoder model state and its copy of the registers
   logic        cfg_kind;
   logic [15:0] cfg_timeout;
   logic [10:0] cfg_temp_off;
   logic [10:0] cfg_hum_off;
   bit          rd_busy;
   logic [6:0]  rd_edges;
   logic [31:0] rd_last_edge;
   logic [31:0] rd_low;
   logic [39:0] rd_bits;

   reading_type expected_readings[$];
   reading_type typed_reading;
   bit          typed_pending = 1'b0;
   bit          tx_idle = 1'b1;
   bit          rx_idle = 1'b0;
   bit          hold_request = 1'b0;
   int          item_count = 0;
   int          reading_count = 0;
   int          fail_count = 0;

   script_row_type script_rows [0:9] = '{
      '{SEQ_STRAY,   32'd0,          40'd0,            0,  32'd0,          1'b0, NO_READING},
      '{SEQ_FRAME,   32'd0,          40'd0,            0,  32'd0,          1'b1,
        '{swhsd_pkg::ST_GOOD, 18'd0, 17'd0, 40'd0}},
      '{SEQ_FRAME,   32'h8000_0000,  40'hFF_FFFF_FF00, 0,  32'd0,          1'b1,
        '{swhsd_pkg::ST_BAD_SUM, 18'd0, 17'd0, 40'hFF_FFFF_FF00}},
      '{SEQ_FRAME,   32'hFFFF_FFF0,  40'h01_0203_040A, 0,  32'd0,          1'b0, NO_READING},
      '{SEQ_FRAME,   32'd1000,       40'h02_0503_858F, 0,  32'd0,          1'b0, NO_READING},
      '{SEQ_FRAME,   32'hFFFF_FFFF,  40'hFF_FFFF_FFFF, 0,  32'd0,          1'b1,
        '{swhsd_pkg::ST_BAD_SUM, 18'd0, 17'd0, 40'hFF_FFFF_FFFF}},
      '{SEQ_TIMEOUT, 32'd100,        40'd0,            0,  32'd5000,       1'b0, NO_READING},
      '{SEQ_TIMEOUT, 32'd0,          40'd0,            0,  32'd5001,       1'b1,
        '{swhsd_pkg::ST_TIMEOUT, 18'd0, 17'd0, 40'd0}},
      '{SEQ_TIMEOUT, 32'd12345,      40'd0,            50, 32'hFFFF_FFFF,  1'b1,
        '{swhsd_pkg::ST_TIMEOUT, 18'd0, 17'd0, 40'd0}},
      '{SEQ_RESTART, 32'd500,        40'h12_3456_7814, 30, 32'd0,          1'b0, NO_READING}
   };

   single_wire_humidity_sensor_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic reading_type decode_frame(input logic [39:0] bits);
      int b0, b1, b2, b3, b4, hum, temp;
      reading_type r;
      b0 = int'(bits[39:32]);
      b1 = int'(bits[31:24]);
      b2 = int'(bits[23:16]);
      b3 = int'(bits[15:8]);
      b4 = int'(bits[7:0]);
      r = '0;
      r.raw = bits;
      if (b4 != ((b0 + b1 + b2 + b3) & 8'hFF)) begin
         r.status = swhsd_pkg::ST_BAD_SUM;
         return r;
      end
      if (cfg_kind) begin
         hum = (b0 << 8) | b1;
         temp = ((b2 & 'h7F) << 8) | b3;
         if (b2 & 'h80) temp = -temp;
      end else begin
         hum = b0 * 10 + b1;
         temp = (b3 & 'h80) ? -10 - b2 * 10 : b2 * 10;
         temp = temp + (b3 & 'h0F);
      end
      hum = hum + $signed(cfg_hum_off);
      temp = temp + $signed(cfg_temp_off);
      r.status = swhsd_pkg::ST_GOOD;
      r.hum = hum[17:0];
      r.temp = temp[16:0];
      return r;
   endfunction

   function automatic bit decode_step(input logic [1:0] c, input logic [31:0] now,
                                      output reading_type r);
      logic [31:0] gap;
      int k;
      r = '0;
      if (c == swhsd_pkg::CMD_START) begin
         rd_busy = 1'b1;
         rd_edges = '0;
         rd_last_edge = now;
         rd_low = '0;
         rd_bits = '0;
         return 1'b0;
      end
      if (!rd_busy) return 1'b0;
      if (c == swhsd_pkg::CMD_EDGE) begin
         gap = now - rd_last_edge;
         rd_last_edge = now;
         if (rd_edges >= LEAD_COUNT) begin
            k = rd_edges - LEAD_COUNT;
            if (!k[0]) rd_low = gap;
            else rd_bits = {rd_bits[38:0], gap > rd_low};
         end
         rd_edges = rd_edges + 7'd1;
         if (rd_edges >= READING_EDGES) begin
            rd_busy = 1'b0;
            r = decode_frame(rd_bits);
            return 1'b1;
         end
         return 1'b0;
      end
      if (c == swhsd_pkg::CMD_CHECK && now - rd_last_edge > cfg_timeout) begin
         rd_busy = 1'b0;
         r.status = swhsd_pkg::ST_TIMEOUT;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [39:0] make_frame(input bit good_sum);
      logic [7:0] by [0:3];
      logic [7:0] sum;
      sum = '0;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 7))
            0: by[i] = 8'h00;
            1: by[i] = 8'hFF;
            2: by[i] = 8'h80;
            3: by[i] = 8'h7F;
            default: by[i] = 8'($urandom);
         endcase
      end
      // negative zero in the sign-magnitude format
      if ($urandom_range(0, 7) == 0) begin
         by[2] = 8'h80;
         by[3] = 8'h00;
      end
      for (int i = 0; i < 4; i++) sum = sum + by[i];
      return {by[0], by[1], by[2], by[3], good_sum ? sum : 8'($urandom)};
   endfunction

   task automatic send_item(input logic [1:0] c, input logic [31:0] t);
      int gap;
      reading_type r;
      gap = tx_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= c;
      req_bus.time_us <= t;
      do @(posedge clock); while (!req_bus.ready);
      if (c == swhsd_pkg::CMD_START || rd_busy) item_count++;
      if (decode_step(c, t, r)) begin
         if (typed_pending) begin
            r = typed_reading;
            typed_pending = 1'b0;
         end
         expected_readings.push_back(r);
         reading_count++;
      end
   endtask

   // edges of one reading from its start: lead edges, then low/high pairs per bit
   task automatic send_edges(inout logic [31:0] t, input logic [39:0] bits, input int count,
                             input int check_odds);
      logic [31:0] low_gap, gap;
      int k;
      low_gap = '0;
      for (int e = 0; e < count; e++) begin
         if (e < LEAD_COUNT) begin
            gap = $urandom_range(20, 90);
         end else begin
            k = e - LEAD_COUNT;
            if (k % 2 == 0) begin
               low_gap = $urandom_range(1, 80);
               gap = low_gap;
            end else if (bits[39 - k / 2]) begin
               gap = low_gap + $urandom_range(1, 60);
            end else begin
               gap = low_gap - $urandom_range(0, low_gap);
            end
         end
         t = t + gap;
         send_item(swhsd_pkg::CMD_EDGE, t);
         if (check_odds > 0 && $urandom_range(1, check_odds) == 1)
            send_item(swhsd_pkg::CMD_CHECK, t + $urandom_range(0, cfg_timeout));
         if (check_odds > 0 && $urandom_range(1, 4 * check_odds) == 1)
            send_item(CMD_UNUSED, $urandom);
      end
   endtask

   task automatic send_reading(input logic [31:0] base, input logic [39:0] bits,
                               input int check_odds);
      logic [31:0] t;
      t = base;
      send_item(swhsd_pkg::CMD_START, t);
      send_edges(t, bits, READING_EDGES, check_odds);
   endtask

   task automatic send_timeout(input logic [31:0] base, input int count,
                               input logic [31:0] gap);
      logic [31:0] t;
      t = base;
      send_item(swhsd_pkg::CMD_START, t);
      send_edges(t, make_frame(1'b1), count, 0);
      send_item(swhsd_pkg::CMD_CHECK, t + gap);
   endtask

   task automatic send_restart(input logic [31:0] base, input logic [39:0] bits,
                               input int count);
      logic [31:0] t;
      t = base;
      send_item(swhsd_pkg::CMD_START, t);
      send_edges(t, make_frame(1'($urandom_range(0, 1))), count, 0);
      send_reading(t + $urandom_range(0, 500), bits, 0);
   endtask

   task automatic run_random_reading();
      int pick;
      logic [31:0] gap;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         send_reading($urandom, make_frame($urandom_range(0, 9) != 0), 8);
      end else if (pick < 78) begin
         gap = $urandom_range(0, 1) ? 32'(cfg_timeout) + 32'd1 + $urandom_range(0, 100000)
                                    : $urandom_range(0, cfg_timeout);
         send_timeout($urandom, $urandom_range(0, READING_EDGES - 1), gap);
      end else if (pick < 88) begin
         send_restart($urandom, make_frame(1'b1), $urandom_range(1, READING_EDGES - 1));
      end else begin
         repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), $urandom);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         swhsd_pkg::REG_SENSOR_KIND: cfg_kind = value[0];
         swhsd_pkg::REG_TIMEOUT:     cfg_timeout = value[15:0];
         swhsd_pkg::REG_TEMP_OFF:    cfg_temp_off = value[10:0];
         swhsd_pkg::REG_HUM_OFF:     cfg_hum_off = value[10:0];
         default: ;
      endcase
   endtask

   // drops any open reading with a fresh start that ends in a timeout, then waits for the pipeline to empty
   task automatic drain_readings();
      send_timeout($urandom, 0, 32'(cfg_timeout) + 32'd1);
      req_bus.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side
   initial begin
      int stall;
      reading_type want;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            stall = rx_idle ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (expected_readings.size() == 0) begin
            $error("unexpected response transaction: status %0d raw_frame %h",
                   rsp_bus.status, rsp_bus.raw_frame);
            fail_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.humidity_tenths !== want.hum) begin
               $error("humidity_tenths: expected %0d, actual %0d",
                      $signed(want.hum), rsp_bus.humidity_tenths);
               fail_count++;
            end
            if (rsp_bus.temperature_tenths !== want.temp) begin
               $error("temperature_tenths: expected %0d, actual %0d",
                      $signed(want.temp), rsp_bus.temperature_tenths);
               fail_count++;
            end
            if (rsp_bus.raw_frame !== want.raw) begin
               $error("raw_frame: expected %h, actual %h", want.raw, rsp_bus.raw_frame);
               fail_count++;
            end
         end
      end
   end

   // request side and register setup
   initial begin
      int phase;
      logic [31:0] kind_v, timeout_v, toff_v, hoff_v;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= swhsd_pkg::CMD_START;
      req_bus.time_us <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cfg_kind = 1'b0;
      cfg_timeout = swhsd_pkg::TIMEOUT_RESET;
      cfg_temp_off = '0;
      cfg_hum_off = '0;
      rd_busy = 1'b0;
      rd_edges = '0;
      rd_last_edge = '0;
      rd_low = '0;
      rd_bits = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i]) begin
         typed_pending = script_rows[i].typed;
         typed_reading = script_rows[i].want;
         case (script_rows[i].kind)
            SEQ_STRAY: begin
               send_item(swhsd_pkg::CMD_EDGE, script_rows[i].base);
               send_item(swhsd_pkg::CMD_CHECK, 32'hFFFF_FFFF);
               send_item(CMD_UNUSED, script_rows[i].base);
            end
            SEQ_FRAME:   send_reading(script_rows[i].base, script_rows[i].frame, 0);
            SEQ_TIMEOUT: send_timeout(script_rows[i].base, script_rows[i].edges,
                                      script_rows[i].gap);
            SEQ_RESTART: send_restart(script_rows[i].base, script_rows[i].frame,
                                      script_rows[i].edges);
            default: ;
         endcase
         typed_pending = 1'b0;
      end

      phase = 0;
      while (phase < 4 || item_count < ITEM_TARGET || reading_count < READING_TARGET) begin
         drain_readings();
         case (phase)
            0: begin
               kind_v = 32'd1; timeout_v = 32'd65535;
               toff_v = 32'(1000); hoff_v = 32'(-1000);
            end
            1: begin
               kind_v = 32'd0; timeout_v = 32'd1;
               toff_v = 32'(-1000); hoff_v = 32'(1000);
            end
            2: begin
               kind_v = 32'd1; timeout_v = 32'd0;
               toff_v = 32'(-1024); hoff_v = 32'(1023);
            end
            3: begin
               kind_v = 32'd0; timeout_v = 32'(swhsd_pkg::TIMEOUT_RESET);
               toff_v = 32'd0; hoff_v = 32'd0;
            end
            default: begin
               kind_v = $urandom_range(0, 1); timeout_v = $urandom_range(0, 65535);
               toff_v = $urandom_range(0, 2047); hoff_v = $urandom_range(0, 2047);
            end
         endcase
         csr_write(swhsd_pkg::REG_SENSOR_KIND, kind_v);
         csr_write(swhsd_pkg::REG_TIMEOUT, timeout_v);
         csr_write(swhsd_pkg::REG_TEMP_OFF, toff_v);
         csr_write(swhsd_pkg::REG_HUM_OFF, hoff_v);
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         if (phase == 3) begin
            // back-to-back timeouts against a stalled response side
            tx_idle = 1'b0;
            hold_request = 1'b1;
            repeat (20) send_timeout($urandom, 0,
                                     32'(cfg_timeout) + 32'd1 + $urandom_range(0, 1000));
         end
         repeat (4) run_random_reading();
         phase++;
      end

      drain_readings();
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
